// File: rtl/tlpt_pkg.sv
// Shared types and constants of the two-level page table block.
package tlpt_pkg;

  // Number of page-table slots in the pool (1 to 128).
  localparam int TABLE_SLOTS = 32;

  localparam int VA_W      = 32;
  localparam int PA_W      = 32;
  localparam int FLAGS_W   = 12;
  localparam int OFF_W     = 12;
  localparam int DIR_IDX_W = 10;
  localparam int TBL_IDX_W = 10;
  localparam int FRAME_W   = PA_W - OFF_W;
  localparam int DIR_DEPTH = 1 << DIR_IDX_W;
  localparam int TBL_DEPTH = 1 << TBL_IDX_W;

  // Slot number width, and the width of the allocation count (0 to TABLE_SLOTS).
  localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
  localparam int POOL_DEPTH = TABLE_SLOTS * TBL_DEPTH;
  localparam int POOL_AW    = SLOT_W + TBL_IDX_W;

  // Flag bit positions in a table entry and in the page flags.
  localparam int FLAG_PRESENT_BIT = 0;
  localparam int FLAG_USER_BIT    = 2;

  // Request commands.
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_MAP       = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NOT_MAPPED = 2'd1,
    STATUS_NO_SLOT    = 2'd2
  } status_t;

  // One page directory entry: a slot number in place of a physical pointer.
  typedef struct packed {
    logic              present;
    logic              writable;
    logic              user;
    logic [SLOT_W-1:0] slot;
  } dir_entry_t;

endpackage

// File: rtl/tlpt_if.sv
// Request and result channel interfaces of the two-level page table block.
interface tlpt_req_if import tlpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [VA_W-1:0]    virt_addr;
  logic [PA_W-1:0]    phys_addr;
  logic [FLAGS_W-1:0] page_flags;

  modport source (output valid, command, virt_addr, phys_addr, page_flags, input ready);
  modport sink   (input valid, command, virt_addr, phys_addr, page_flags, output ready);
endinterface

interface tlpt_rsp_if import tlpt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] phys_result;
  status_t         status;

  modport source (output valid, phys_result, status, input ready);
  modport sink   (input valid, phys_result, status, output ready);
endinterface

// File: rtl/two_level_page_table_map_translate.sv
// Two-level page table with map and translate requests over a directory and a table pool.
// Requests are handled one at a time. After reset the block sweeps the 1024-entry
// directory memory, one entry a cycle, and takes no request until the sweep is done.
// A translate request whose directory entry is absent, and a map request that lands in
// a table already allocated, finish at the directory read (accept, then directory read);
// a translate that reaches the table adds the dependent read of the pool memory. A map
// request that allocates a new table goes on to a sweep in which the new table is
// cleared one entry a cycle through the single write port of the pool memory, with the
// new entry written in the same sweep. A result waits in an output register, and a
// second holding register lets the block finish an item while the previous result is
// still pending.
module two_level_page_table_map_translate import tlpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tlpt_req_if.sink   in_ch,
  tlpt_rsp_if.source out_ch
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_PTE,
    S_WIPE,
    S_HOLD
  } state_t;

  state_t             state_r, state_nxt;
  logic [TBL_IDX_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   next_free_r, next_free_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               cmd_r, cmd_nxt;
  logic [VA_W-1:0]    va_r, va_nxt;
  logic [PA_W-1:0]    pa_r, pa_nxt;
  logic [FLAGS_W-1:0] flags_r, flags_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PA_W-1:0]    out_phys_r, out_phys_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [PA_W-1:0]    hold_phys_r, hold_phys_nxt;
  status_t            hold_status_r, hold_status_nxt;

  // Memory ports.
  dir_entry_t           dir_mem [DIR_DEPTH];
  logic                 dir_we;
  logic [DIR_IDX_W-1:0] dir_waddr;
  dir_entry_t           dir_wdata;
  logic [DIR_IDX_W-1:0] dir_raddr;
  dir_entry_t           dir_q;

  logic [PA_W-1:0]      pool_mem [POOL_DEPTH];
  logic                 pool_we;
  logic [POOL_AW-1:0]   pool_waddr;
  logic [PA_W-1:0]      pool_wdata;
  logic [POOL_AW-1:0]   pool_raddr;
  logic [PA_W-1:0]      pool_q;

  // Fields of the request under way.
  logic [TBL_IDX_W-1:0] tbl_idx;
  logic [OFF_W-1:0]     offset;
  logic [PA_W-1:0]      new_pte;
  logic                 slot_ok;
  logic                 out_free;
  logic                 emit;
  logic [PA_W-1:0]      res_phys;
  status_t              res_status;

  assign tbl_idx  = va_r[OFF_W +: TBL_IDX_W];
  assign offset   = va_r[OFF_W-1:0];
  assign new_pte  = {pa_r[PA_W-1:OFF_W], flags_r[OFF_W-1:1], 1'b1};
  assign slot_ok  = ({1'b0, dir_q.slot} < (SLOT_W + 1)'(TABLE_SLOTS));
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.phys_result = out_phys_r;
  assign out_ch.status      = out_status_r;

  // Directory memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    dir_q <= dir_mem[dir_raddr];
  end

  // Table pool memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_waddr] <= pool_wdata;
    end
    pool_q <= pool_mem[pool_raddr];
  end

  // Reads are issued every cycle; the data is used only in the state that follows.
  assign dir_raddr  = in_ch.virt_addr[VA_W-1 -: DIR_IDX_W];
  assign pool_raddr = {dir_q.slot, tbl_idx};

  // Sequencer: walk, allocation sweep and result hand-off.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    next_free_nxt   = next_free_r;
    slot_nxt        = slot_r;
    cmd_nxt         = cmd_r;
    va_nxt          = va_r;
    pa_nxt          = pa_r;
    flags_nxt       = flags_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_phys_nxt    = out_phys_r;
    out_status_nxt  = out_status_r;
    hold_phys_nxt   = hold_phys_r;
    hold_status_nxt = hold_status_r;
    dir_we          = 1'b0;
    dir_waddr       = va_r[VA_W-1 -: DIR_IDX_W];
    dir_wdata       = dir_q;
    pool_we         = 1'b0;
    pool_waddr      = {dir_q.slot, tbl_idx};
    pool_wdata      = new_pte;
    emit            = 1'b0;
    res_phys        = '0;
    res_status      = STATUS_OK;

    case (state_r)
      S_CLEAR: begin
        // Mark every directory entry absent after reset.
        dir_we    = 1'b1;
        dir_waddr = cnt_r;
        dir_wdata = '0;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.command;
          va_nxt    = in_ch.virt_addr;
          pa_nxt    = in_ch.phys_addr;
          flags_nxt = in_ch.page_flags;
          state_nxt = S_DIR;
        end
      end

      S_DIR: begin
        if (cmd_r == CMD_TRANSLATE) begin
          if (dir_q.present && slot_ok) begin
            state_nxt = S_PTE;
          end else begin
            emit       = 1'b1;
            res_status = STATUS_NOT_MAPPED;
          end
        end else if (dir_q.present) begin
          // Table exists: update the entry and fold the user flag upwards.
          pool_we        = slot_ok;
          dir_we         = 1'b1;
          dir_wdata.user = dir_q.user | flags_r[FLAG_USER_BIT];
          emit           = 1'b1;
        end else if (next_free_r >= CNT_W'(TABLE_SLOTS)) begin
          emit       = 1'b1;
          res_status = STATUS_NO_SLOT;
        end else begin
          // Allocate the next slot and start clearing it.
          dir_we             = 1'b1;
          dir_wdata.present  = 1'b1;
          dir_wdata.writable = 1'b1;
          dir_wdata.user     = flags_r[FLAG_USER_BIT];
          dir_wdata.slot     = next_free_r[SLOT_W-1:0];
          slot_nxt           = next_free_r[SLOT_W-1:0];
          next_free_nxt      = next_free_r + 1'b1;
          cnt_nxt            = '0;
          state_nxt          = S_WIPE;
        end
      end

      S_PTE: begin
        emit = 1'b1;
        if (pool_q[FLAG_PRESENT_BIT]) begin
          res_phys = {pool_q[PA_W-1:OFF_W], offset};
        end else begin
          res_status = STATUS_NOT_MAPPED;
        end
      end

      S_WIPE: begin
        // Clear the new table, writing the mapped entry as the sweep passes it.
        pool_we    = 1'b1;
        pool_waddr = {slot_r, cnt_r};
        pool_wdata = (cnt_r == tbl_idx) ? new_pte : '0;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          emit = 1'b1;
        end
      end

      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_phys_nxt   = hold_phys_r;
          out_status_nxt = hold_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Result goes to the output register, or waits in the holding register.
    if (emit) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_phys_nxt   = res_phys;
        out_status_nxt = res_status;
        state_nxt      = S_IDLE;
      end else begin
        hold_phys_nxt   = res_phys;
        hold_status_nxt = res_status;
        state_nxt       = S_HOLD;
      end
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      next_free_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r        <= slot_nxt;
    cmd_r         <= cmd_nxt;
    va_r          <= va_nxt;
    pa_r          <= pa_nxt;
    flags_r       <= flags_nxt;
    out_phys_r    <= out_phys_nxt;
    out_status_r  <= out_status_nxt;
    hold_phys_r   <= hold_phys_nxt;
    hold_status_r <= hold_status_nxt;
  end

endmodule

// File: test/page_walk_checker.sv
// Checker for the page table block: predicts every result from the requests and compares it.
`timescale 1ns / 1ps

module page_walk_checker import tlpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tlpt_req_if  in_ch,
  tlpt_rsp_if  out_ch,
  output int   fail_count,
  output int   outstanding
);

  // One predicted result.
  typedef struct packed {
    logic [PA_W-1:0] phys;
    status_t         status;
  } walk_result_t;

  // Shadow copy of the directory, the table pool and the allocation count.
  dir_entry_t      page_dir [DIR_DEPTH];
  logic [PA_W-1:0] table_mem [TABLE_SLOTS][TBL_DEPTH];
  int unsigned     slots_used;

  walk_result_t    pending_results [$];
  int              mismatches;

  initial begin
    mismatches  = 0;
  end

  // Applies one request to the shadow state and returns the result it must give.
  function automatic walk_result_t walk_and_update(input logic cmd,
                                                   input logic [VA_W-1:0] va,
                                                   input logic [PA_W-1:0] pa,
                                                   input logic [FLAGS_W-1:0] flags);
    walk_result_t          res;
    logic [DIR_IDX_W-1:0]  di;
    logic [TBL_IDX_W-1:0]  ti;
    logic [PA_W-1:0]       pte;
    di = va[VA_W-1 -: DIR_IDX_W];
    ti = va[OFF_W +: TBL_IDX_W];
    res.phys   = '0;
    res.status = STATUS_OK;
    if (cmd == CMD_MAP) begin
      // An absent directory entry needs a fresh table, if one is left.
      if (!page_dir[di].present) begin
        if (slots_used >= TABLE_SLOTS) begin
          res.status = STATUS_NO_SLOT;
          return res;
        end
        for (int k = 0; k < TBL_DEPTH; k++) table_mem[slots_used][k] = '0;
        page_dir[di].present  = 1'b1;
        page_dir[di].writable = 1'b1;
        page_dir[di].user     = 1'b0;
        page_dir[di].slot     = SLOT_W'(slots_used);
        slots_used++;
      end
      if (flags[FLAG_USER_BIT]) page_dir[di].user = 1'b1;
      table_mem[page_dir[di].slot][ti] =
        {pa[PA_W-1:OFF_W], {OFF_W{1'b0}}} | PA_W'(flags) | PA_W'(1);
    end else begin
      // Translation: both levels must carry their present bit.
      if (!page_dir[di].present) begin
        res.status = STATUS_NOT_MAPPED;
      end else begin
        pte = table_mem[page_dir[di].slot][ti];
        if (!pte[FLAG_PRESENT_BIT]) res.status = STATUS_NOT_MAPPED;
        else res.phys = {pte[PA_W-1:OFF_W], va[OFF_W-1:0]};
      end
    end
    return res;
  endfunction

  // Results are compared before new requests are predicted on the same edge.
  always @(posedge clk) begin
    walk_result_t want;
    if (!rst_n) begin
      for (int d = 0; d < DIR_DEPTH; d++) page_dir[d] = '0;
      slots_used = 0;
      pending_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result phys_result %h status %0d", $time,
                   out_ch.phys_result, out_ch.status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.phys_result !== want.phys) begin
            $display("%0t: phys_result expected %h actual %h", $time,
                     want.phys, out_ch.phys_result);
            mismatches++;
          end
          if (out_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_ch.status);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(walk_and_update(in_ch.command, in_ch.virt_addr,
                                                  in_ch.phys_addr, in_ch.page_flags));
      end
    end
    fail_count  <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

// File: test/tb.sv
// Top of the page table testbench: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module tb import tlpt_pkg::*; ();

  localparam int RANDOM_REQUESTS = 550;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int HOLD_AFTER      = 450;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 1100;
  localparam int DIR_CHOICES     = 48;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        rsp_ready  = 1'b0;
  logic [1:0]  idle_phase = 2'd0;
  int unsigned accepted   = 0;
  int unsigned cycles     = 0;
  int          hold_left  = 0;
  logic        hold_done  = 1'b0;
  int          req_idle_pct;
  int          fail_count;
  int          outstanding;

  logic [DIR_IDX_W-1:0]     dir_choice [DIR_CHOICES];
  logic [VA_W-OFF_W-1:0]    mapped_pages [$];

  tlpt_req_if in_if();
  tlpt_rsp_if out_if();

  assign out_if.ready = rsp_ready;

  two_level_page_table_map_translate dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  page_walk_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Count of requests taken by the block, used to time the long stall.
  always @(posedge clk) begin
    if (in_if.valid && in_if.ready) accepted <= accepted + 1;
  end

  // Result side: random stalls per phase, and one long hold-off that fills the block.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted >= HOLD_AFTER) begin
      rsp_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      case (idle_phase)
        2'd0: rsp_ready <= ($urandom_range(99) >= 67);
        2'd1: rsp_ready <= ($urandom_range(99) >= 9);
        default: rsp_ready <= 1'b1;
      endcase
    end
  end

  // Offers one request and waits until it is taken, then idles at random.
  task automatic send_request(input logic cmd, input logic [VA_W-1:0] va,
                              input logic [PA_W-1:0] pa, input logic [FLAGS_W-1:0] flags);
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.virt_addr  <= va;
    in_if.phys_addr  <= pa;
    in_if.page_flags <= flags;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (cmd == CMD_MAP) mapped_pages.push_back(va[VA_W-1:OFF_W]);
    while ($urandom_range(99) < req_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Mostly maps into a limited set of directory entries and translations of mapped
  // pages, so that tables fill and the slot pool runs dry; the rest is noise.
  task automatic send_random_request();
    int unsigned          pick;
    logic [VA_W-1:0]      va;
    logic [DIR_IDX_W-1:0] di;
    pick = $urandom_range(99);
    di   = dir_choice[$urandom_range(DIR_CHOICES - 1)];
    if (pick < 40) begin
      if (mapped_pages.size() != 0 && $urandom_range(99) < 30)
        va = {mapped_pages[$urandom_range(mapped_pages.size() - 1)], OFF_W'($urandom)};
      else
        va = {di, TBL_IDX_W'($urandom), OFF_W'($urandom)};
      send_request(CMD_MAP, va, $urandom, FLAGS_W'($urandom));
    end else if (pick < 80 && mapped_pages.size() != 0) begin
      va = {mapped_pages[$urandom_range(mapped_pages.size() - 1)], OFF_W'($urandom)};
      send_request(CMD_TRANSLATE, va, $urandom, FLAGS_W'($urandom));
    end else if (pick < 90) begin
      va = {di, TBL_IDX_W'($urandom), OFF_W'($urandom)};
      send_request(CMD_TRANSLATE, va, $urandom, FLAGS_W'($urandom));
    end else begin
      send_request(CMD_TRANSLATE, $urandom, $urandom, FLAGS_W'($urandom));
    end
  endtask

  initial begin
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_TRANSLATE;
    in_if.virt_addr  <= '0;
    in_if.phys_addr  <= '0;
    in_if.page_flags <= '0;
    req_idle_pct = 9;

    dir_choice[0] = '0;
    dir_choice[1] = '1;
    dir_choice[2] = DIR_IDX_W'(1);
    for (int i = 3; i < DIR_CHOICES; i++) dir_choice[i] = DIR_IDX_W'($urandom);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: empty directory, address extremes, remapping and flag bits.
    send_request(CMD_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 12'h000);
    send_request(CMD_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    send_request(CMD_MAP,       32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    send_request(CMD_TRANSLATE, 32'h0000_0FFF, 32'h0000_0000, 12'h000);
    send_request(CMD_TRANSLATE, 32'h0000_1000, 32'h0000_0000, 12'h000);
    send_request(CMD_MAP,       32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
    send_request(CMD_TRANSLATE, 32'hFFFF_F000, 32'h0000_0000, 12'h000);
    send_request(CMD_TRANSLATE, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
    send_request(CMD_TRANSLATE, 32'hFFBF_FFFF, 32'h0000_0000, 12'h000);
    // Remap the first page with a user flag and a physical address with offset bits.
    send_request(CMD_MAP,       32'h0000_0ABC, 32'h1234_5ABC, 12'h004);
    send_request(CMD_TRANSLATE, 32'h0000_0123, 32'h0000_0000, 12'h000);
    send_request(CMD_MAP,       32'h0040_0000, 32'h8000_0000, 12'h800);
    send_request(CMD_TRANSLATE, 32'h0040_0800, 32'h0000_0000, 12'h000);
    send_request(CMD_MAP,       32'h003F_F000, 32'h7FFF_F000, 12'h002);
    send_request(CMD_TRANSLATE, 32'h003F_FABC, 32'h0000_0000, 12'h000);
    send_request(CMD_TRANSLATE, 32'h003F_E000, 32'h0000_0000, 12'h000);
    send_request(CMD_MAP,       32'h0040_0000, 32'h5555_5FFF, 12'hAAA);
    send_request(CMD_TRANSLATE, 32'h0040_0FFF, 32'h0000_0000, 12'h000);

    // Random requests in three idling phases.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 3) begin
        idle_phase   <= 2'd1;
        req_idle_pct = 67;
      end
      if (n == 2 * RANDOM_REQUESTS / 3) begin
        idle_phase   <= 2'd2;
        req_idle_pct = 0;
      end
      send_random_request();
    end
    in_if.valid <= 1'b0;

    // Drain the remaining results, then allow for any late stray result.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
